/* rtl/cdq_pkg.sv */
// cdq_pkg: shared types and constants for the circular deque.
// No dependencies; read first by all other files.
package cdq_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic              shift_right;  // push front
        logic              shift_left;   // pop front
        logic              append;       // push rear
        logic              drop;         // pop rear
        logic [DATA_W-1:0] push_value;
    } cell_op_t;

endpackage

/* rtl/cdq_if.sv */
// cdq_req_if / cdq_rsp_if: valid/ready channels for requests and results.
// Depends on cdq_pkg.
interface cdq_req_if
    import cdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_rsp_if
    import cdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic                     ok;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;

    modport source (output valid, output popped_value, output ok, output is_empty,
                    output is_full, output front_value, output rear_value, input ready);
    modport sink   (input valid, input popped_value, input ok, input is_empty,
                    input is_full, input front_value, input rear_value, output ready);
endinterface

/* rtl/circular_deque.sv */
// circular_deque: fixed-capacity double-ended queue kept in a row of cells.
// A request accepted in S_IDLE passes through S_SETTLE, which registers the row status
// and raises the result valid; no new request is taken until S_SETTLE has gathered the
// rear entry from the row (AND-OR over all cells) into the result register, nor while a result is stalled.
// Reset: rst_n asynchronous, active low; deque empty, no result pending.
// Depends on cdq_pkg, cdq_if and cdq_cell.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    cdq_req_if.sink    request,
    cdq_rsp_if.source  result
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_SETTLE
    } state_t;

    state_t            state_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] popped_reg;
    logic [DATA_W-1:0] popped_next;
    logic              ok_reg;
    logic              ok_next;
    logic              empty_reg;
    logic              full_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] rear_reg;

    logic              accept;
    logic              push_ok;
    logic              pop_ok;
    cell_op_t          op;
    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic              cell_valid [CAPACITY];
    logic [DATA_W-1:0] rear_tap;

    assign request.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept  = request.valid && request.ready;
    assign push_ok = (count_reg != CNT_FULL);
    assign pop_ok  = (count_reg != '0);

    // rear entry: the valid cell whose right neighbor is empty, or the last cell when valid
    always_comb
    begin
        rear_tap = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i + 1) % CAPACITY]))
            begin
                rear_tap = rear_tap | cell_value[i];
            end
        end
    end

    always_comb
    begin
        op            = '0;
        op.push_value = request.push_value;
        count_next    = count_reg;
        popped_next   = NEG_ONE;
        ok_next       = 1'b0;
        if (accept)
        begin
            unique case (action_t'(request.action))
                ACT_PUSH_FRONT:
                begin
                    op.shift_right = push_ok;
                    ok_next        = push_ok;
                    if (push_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_PUSH_REAR:
                begin
                    op.append = push_ok;
                    ok_next   = push_ok;
                    if (push_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT:
                begin
                    op.shift_left = pop_ok;
                    ok_next       = pop_ok;
                    if (pop_ok)
                    begin
                        count_next  = count_reg - 1'b1;
                        popped_next = cell_value[0];
                    end
                end
                ACT_POP_REAR:
                begin
                    op.drop = pop_ok;
                    ok_next = pop_ok;
                    if (pop_ok)
                    begin
                        count_next  = count_reg - 1'b1;
                        popped_next = rear_tap;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] lv;
        logic              lvld;
        logic [DATA_W-1:0] rv;
        logic              rvld;

        if (g == 0)
        begin : g_first
            assign lv   = request.push_value;
            assign lvld = 1'b1;
        end
        else
        begin : g_mid_l
            assign lv   = cell_value[g-1];
            assign lvld = cell_valid[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign rv   = '0;
            assign rvld = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv   = cell_value[g+1];
            assign rvld = cell_valid[g+1];
        end

        cdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .left_value  (lv),
            .left_valid  (lvld),
            .right_value (rv),
            .right_valid (rvld),
            .value       (cell_value[g]),
            .valid       (cell_valid[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            popped_reg    <= NEG_ONE;
            ok_reg        <= 1'b0;
            empty_reg     <= 1'b1;
            full_reg      <= 1'b0;
            front_reg     <= NEG_ONE;
            rear_reg      <= NEG_ONE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && result.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        count_reg  <= count_next;
                        popped_reg <= popped_next;
                        ok_reg     <= ok_next;
                        state_reg  <= S_SETTLE;
                    end
                end
                S_SETTLE:
                begin
                    out_valid_reg <= 1'b1;
                    empty_reg     <= (count_reg == '0);
                    full_reg      <= (count_reg == CNT_FULL);
                    front_reg     <= (count_reg == '0) ? NEG_ONE : cell_value[0];
                    rear_reg      <= (count_reg == '0) ? NEG_ONE : rear_tap;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.popped_value = popped_reg;
    assign result.ok           = ok_reg;
    assign result.is_empty     = empty_reg;
    assign result.is_full      = full_reg;
    assign result.front_value  = front_reg;
    assign result.rear_value   = rear_reg;

endmodule

/* rtl/cdq_cell.sv */
// cdq_cell: one slot of the deque row, holding a value and a valid bit.
// Depends on cdq_pkg; instantiated by circular_deque.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_op_t          op,
    input  logic [DATA_W-1:0] left_value,
    input  logic              left_valid,
    input  logic [DATA_W-1:0] right_value,
    input  logic              right_valid,
    output logic [DATA_W-1:0] value,
    output logic              valid
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (op.shift_right)
        begin
            value_next = left_value;
            valid_next = left_valid;
        end
        else if (op.shift_left)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (op.append)
        begin
            // first free slot behind the last occupied one
            if (!valid_reg && left_valid)
            begin
                value_next = op.push_value;
                valid_next = 1'b1;
            end
        end
        else if (op.drop)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

/* rtl/cdq_checker.sv */
// cdq_checker: port-level assertions for circular_deque, bound to the top.
// Depends on cdq_pkg.
module cdq_checker
    import cdq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_empty,
    input logic              rsp_full,
    input logic [DATA_W-1:0] rsp_front,
    input logic [DATA_W-1:0] rsp_rear
);

    // one request in flight: no second request in the gather cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken during gather cycle");

    // every accepted request yields a valid result once S_SETTLE has registered it
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("result missing after request");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty |-> (rsp_front == NEG_ONE) && (rsp_rear == NEG_ONE) && !rsp_full)
        else $error("empty deque reports entries");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_empty (result.is_empty),
    .rsp_full  (result.is_full),
    .rsp_front (result.front_value),
    .rsp_rear  (result.rear_value)
);
